@@ sv/acld_pkg.sv @@
// ----------------------------------------------------------------------------
// ASCII command line decoder package
// Keyword table, field widths and shared constants of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package acld_pkg;

	// Default width of the decoded position value.
	localparam int VALUE_BITS_DEF = 31;

	// Bytes seen in a line, saturating at the top of this counter.
	localparam int CHAR_INDEX_BITS = 4;

	// Keyword table geometry.
	localparam int NUM_KEYS  = 9;
	localparam int KEY_BYTES = 8;
	localparam int KEY_LEN_BITS = 4;

	// Keyword slots in the table.
	localparam int KEY_PING    = 0;
	localparam int KEY_ABORT   = 1;
	localparam int KEY_HOME    = 2;
	localparam int KEY_STATUS  = 3;
	localparam int KEY_PSTATUS = 4;
	localparam int KEY_SSTATUS = 5;
	localparam int KEY_ABS_POS = 6;
	localparam int KEY_SLEEP   = 7;
	localparam int KEY_WAKE    = 8;

	// First byte position that may hold a digit of the position value.
	localparam int DIGIT_START = 8;
	localparam int RADIX       = 10;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef logic [7:0] key_text_t [NUM_KEYS][KEY_BYTES];
	typedef logic [KEY_LEN_BITS-1:0] key_len_t [NUM_KEYS];

	// Keyword characters, padded with zero bytes past each keyword's length.
	localparam key_text_t KEY_TEXT = '{
		'{"P", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"A", "B", "O", "R", "T", 8'h00, 8'h00, 8'h00},
		'{"H", "O", "M", "E", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"S", "T", "A", "T", "U", "S", 8'h00, 8'h00},
		'{"P", "S", "T", "A", "T", "U", "S", 8'h00},
		'{"S", "S", "T", "A", "T", "U", "S", 8'h00},
		'{"A", "B", "S", "_", "P", "O", "S", "="},
		'{"S", "L", "E", "E", "P", 8'h00, 8'h00, 8'h00},
		'{"W", "A", "K", "E", 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam key_len_t KEY_LEN = '{
		4'd4, 4'd5, 4'd4, 4'd6, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4
	};

endpackage

`default_nettype wire

@@ sv/acld_line_if.sv @@
// ----------------------------------------------------------------------------
// Command line byte channel
// Carries one character of a command line and its end-of-line mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface acld_line_if;

	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       line_end;

	modport source (output valid, output line_byte, output line_end, input ready);
	modport sink   (input valid, input line_byte, input line_end, output ready);

endinterface

`default_nettype wire

@@ sv/acld_result_if.sv @@
// ----------------------------------------------------------------------------
// Decoded command channel
// Carries the request flags and the position value of one decoded line.
// ----------------------------------------------------------------------------
`default_nettype none

interface acld_result_if
	import acld_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
);

	logic                  valid;
	logic                  ready;
	logic                  pong_request;
	logic                  abort_request;
	logic                  home_request;
	logic                  report_position;
	logic                  report_state;
	logic                  target_valid;
	logic [VALUE_BITS-1:0] target_value;
	logic                  sleep_request;
	logic                  wake_request;

	modport source (
		output valid, input ready,
		output pong_request, output abort_request, output home_request,
		output report_position, output report_state, output target_valid,
		output target_value, output sleep_request, output wake_request
	);
	modport sink (
		input valid, output ready,
		input pong_request, input abort_request, input home_request,
		input report_position, input report_state, input target_valid,
		input target_value, input sleep_request, input wake_request
	);

endinterface

`default_nettype wire

@@ sv/ascii_command_line_decoder.sv @@
// ----------------------------------------------------------------------------
// ASCII command line decoder
// Matches a byte stream against the command keywords and emits one decoded
// result per line, with the saturating ABS_POS= value.
// ----------------------------------------------------------------------------
// Path: the final byte of a line enters the input register on its transfer,
// and its result is loaded from there into the result register.
// Throughput: one byte per cycle. A final byte waits in the input register
// while the result register still holds a result that has not been
// transferred, so a stalled receiver holds up the sender only at line ends.
// Reset: the line state returns to an empty line and no byte or result is held.
`default_nettype none

module ascii_command_line_decoder
	import acld_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	acld_line_if.sink    cmd,
	acld_result_if.source res
);

	localparam int SUM_BITS = VALUE_BITS + 4;
	localparam logic [CHAR_INDEX_BITS-1:0] INDEX_MAX = '1;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Line state.
	logic [CHAR_INDEX_BITS-1:0] char_index_q;
	logic [NUM_KEYS-1:0]        alive_q;
	logic                       digits_q;
	logic [VALUE_BITS-1:0]      accum_q;

	// Result register.
	logic                  out_valid_q;
	logic                  pong_q, abort_q, home_q, rpos_q, rstate_q;
	logic                  tvalid_q, sleep_q, wake_q;
	logic [VALUE_BITS-1:0] tvalue_q;

	logic out_free;
	logic fire_s1;

	logic [NUM_KEYS-1:0]        alive_next;
	logic [NUM_KEYS-1:0]        hit;
	logic [CHAR_INDEX_BITS:0]   count;
	logic                       is_digit;
	logic                       digits_next;
	logic [VALUE_BITS-1:0]      accum_next;
	logic [SUM_BITS-1:0]        sum;
	logic [CHAR_INDEX_BITS-1:0] index_next;

	// Handshake: a byte leaves the input register unless it ends a line and
	// the result register is still occupied.
	assign out_free  = !out_valid_q || res.ready;
	assign fire_s1   = valid_s1 && (!last_s1 || out_free);
	assign cmd.ready = !valid_s1 || fire_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			byte_s1 <= cmd.line_byte;
			last_s1 <= cmd.line_end;
		end
	end

	// Keyword compare: a keyword drops out at the first differing byte
	// within its length.
	always_comb begin
		alive_next = alive_q;
		hit        = '0;
		count      = {1'b0, char_index_q} + 1'b1;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if ({1'b0, char_index_q} < {1'b0, KEY_LEN[k]}
					&& KEY_TEXT[k][char_index_q[2:0]] != byte_s1) begin
				alive_next[k] = 1'b0;
			end
			hit[k] = alive_next[k] && (count >= {1'b0, KEY_LEN[k]});
		end
	end

	// Value accumulate with saturation: past the top, the value pins there.
	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign sum = SUM_BITS'(accum_q) * SUM_BITS'(RADIX)
		+ SUM_BITS'(byte_s1 - CHAR_ZERO);

	always_comb begin
		digits_next = digits_q;
		accum_next  = accum_q;
		if (char_index_q >= CHAR_INDEX_BITS'(DIGIT_START) && digits_q) begin
			if (is_digit) begin
				if (sum > SUM_BITS'({VALUE_BITS{1'b1}})) begin
					accum_next = '1;
				end else begin
					accum_next = sum[VALUE_BITS-1:0];
				end
			end else begin
				digits_next = 1'b0;
			end
		end
	end

	assign index_next = (char_index_q != INDEX_MAX) ? char_index_q + 1'b1 : char_index_q;

	// Line state: cleared after the final byte of each line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_index_q <= '0;
			alive_q      <= '1;
			digits_q     <= 1'b1;
			accum_q      <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				char_index_q <= '0;
				alive_q      <= '1;
				digits_q     <= 1'b1;
				accum_q      <= '0;
			end else begin
				char_index_q <= index_next;
				alive_q      <= alive_next;
				digits_q     <= digits_next;
				accum_q      <= accum_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire_s1 && last_s1) begin
			pong_q   <= hit[KEY_PING];
			abort_q  <= hit[KEY_ABORT];
			home_q   <= hit[KEY_HOME];
			rpos_q   <= hit[KEY_STATUS] || hit[KEY_PSTATUS];
			rstate_q <= hit[KEY_STATUS] || hit[KEY_SSTATUS];
			tvalid_q <= hit[KEY_ABS_POS];
			tvalue_q <= hit[KEY_ABS_POS] ? accum_next : '0;
			sleep_q  <= hit[KEY_SLEEP];
			wake_q   <= hit[KEY_WAKE];
		end
	end

	assign res.valid           = out_valid_q;
	assign res.pong_request    = pong_q;
	assign res.abort_request   = abort_q;
	assign res.home_request    = home_q;
	assign res.report_position = rpos_q;
	assign res.report_state    = rstate_q;
	assign res.target_valid    = tvalid_q;
	assign res.target_value    = tvalue_q;
	assign res.sleep_request   = sleep_q;
	assign res.wake_request    = wake_q;

	// A byte that does not end a line never waits in the input register.
	a_mid_byte_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !last_s1) |-> cmd.ready)
		else $error("mid-line byte stalled in input register");

	// The keywords have distinct prefixes, so at most one request group fires.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($countones({pong_q, abort_q, home_q, rpos_q || rstate_q,
			tvalid_q, sleep_q, wake_q}) <= 1))
		else $error("more than one keyword matched");

	// The position value is zero unless ABS_POS= matched.
	a_value_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !tvalid_q) |-> (tvalue_q == '0))
		else $error("target value without target valid");

	// After the final byte, the line state is back to an empty line.
	a_line_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> (char_index_q == '0 && alive_q == '1
			&& digits_q && accum_q == '0))
		else $error("line state not cleared after end of line");

endmodule

`default_nettype wire

@@ tb/sv/acld_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command line decoder checker
// Watches the byte and result channels of the decoder. Every byte transfer
// advances a local copy of the line state. The final byte of a line queues
// the decoded command that the block should return. Every result transfer
// is compared field by field with the oldest queued command.
// ----------------------------------------------------------------------------
module acld_checker
	import acld_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	acld_line_if        cmd,
	acld_result_if      res,
	output int unsigned error_count,
	output int unsigned pending,
	output int unsigned byte_count,
	output int unsigned line_count,
	output int unsigned target_count,
	output int unsigned ceiling_count
);

	localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

	typedef struct packed {
		logic                  pong;
		logic                  abort_req;
		logic                  home;
		logic                  rpt_pos;
		logic                  rpt_state;
		logic                  tgt_valid;
		logic [VALUE_BITS-1:0] tgt_value;
		logic                  sleep_req;
		logic                  wake_req;
	} command_t;

	string key_names [NUM_KEYS] = '{
		"PING", "ABORT", "HOME", "STATUS", "PSTATUS",
		"SSTATUS", "ABS_POS=", "SLEEP", "WAKE"
	};

	// Line state of the decoder as seen from its channels.
	logic [3:0]          char_pos  = '0;
	logic [NUM_KEYS-1:0] key_alive = '1;
	logic                in_digits = 1'b1;
	logic [63:0]         value_acc = '0;

	// Decoded commands whose result has not yet been transferred.
	command_t pending_cmds [$];

	function void clear_line();
		char_pos  = '0;
		key_alive = '1;
		in_digits = 1'b1;
		value_acc = '0;
	endfunction

	// Advances the line state by one byte and queues a command at line end.
	task automatic decode_byte(input logic [7:0] b, input logic last);
		int unsigned         pos;
		logic [63:0]         digit;
		logic [NUM_KEYS-1:0] hit;
		command_t            decoded;
		pos = char_pos;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (pos < key_names[k].len() && 8'(key_names[k][pos]) != b) begin
				key_alive[k] = 1'b0;
			end
		end
		// The value is read from position 8 on, up to the first non-digit.
		if (pos >= DIGIT_START && in_digits) begin
			if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
				digit = 64'(b - CHAR_ZERO);
				if (value_acc > (VALUE_MAX - digit) / RADIX) begin
					value_acc = VALUE_MAX;
				end else begin
					value_acc = value_acc * RADIX + digit;
				end
			end else begin
				in_digits = 1'b0;
			end
		end
		if (char_pos != 4'hF) begin
			char_pos = char_pos + 4'd1;
		end
		byte_count++;
		// A keyword matches only when the whole keyword has been seen.
		if (last) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				hit[k] = key_alive[k] && (pos + 1 >= key_names[k].len());
			end
			decoded.pong      = hit[KEY_PING];
			decoded.abort_req = hit[KEY_ABORT];
			decoded.home      = hit[KEY_HOME];
			decoded.rpt_pos   = hit[KEY_STATUS] || hit[KEY_PSTATUS];
			decoded.rpt_state = hit[KEY_STATUS] || hit[KEY_SSTATUS];
			decoded.tgt_valid = hit[KEY_ABS_POS];
			decoded.tgt_value = hit[KEY_ABS_POS] ? value_acc[VALUE_BITS-1:0] : '0;
			decoded.sleep_req = hit[KEY_SLEEP];
			decoded.wake_req  = hit[KEY_WAKE];
			if (hit[KEY_ABS_POS]) begin
				target_count++;
				if (value_acc == VALUE_MAX) begin
					ceiling_count++;
				end
			end
			pending_cmds.push_back(decoded);
			line_count++;
			clear_line();
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
			error_count++;
		end
	endtask

	// Compares one result transfer with the oldest decoded command.
	task automatic check_result();
		command_t want;
		if (pending_cmds.size() == 0) begin
			$display("%0t ns: result with no line waiting, expected none, actual value %0d",
				$time, res.target_value);
			error_count++;
		end else begin
			want = pending_cmds.pop_front();
			compare_field("pong_request", want.pong, res.pong_request);
			compare_field("abort_request", want.abort_req, res.abort_request);
			compare_field("home_request", want.home, res.home_request);
			compare_field("report_position", want.rpt_pos, res.report_position);
			compare_field("report_state", want.rpt_state, res.report_state);
			compare_field("target_valid", want.tgt_valid, res.target_valid);
			compare_field("target_value", want.tgt_value, res.target_value);
			compare_field("sleep_request", want.sleep_req, res.sleep_request);
			compare_field("wake_request", want.wake_req, res.wake_request);
		end
	endtask

	// Results are checked before the byte of the same edge is decoded, so a
	// result that comes too early finds no command waiting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			pending_cmds.delete();
			error_count     = 0;
			pending         = 0;
			byte_count      = 0;
			line_count      = 0;
			target_count    = 0;
			ceiling_count   = 0;
		end else begin
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				check_result();
			end
			if (cmd.valid === 1'b1 && cmd.ready === 1'b1) begin
				decode_byte(cmd.line_byte, cmd.line_end);
			end
			pending = pending_cmds.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command line decoder testbench
// Sends directed command lines and then random ones, mostly keywords with
// random tails and position values, plus cut, corrupted and noise lines.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import acld_pkg::*;

	localparam int VALUE_BITS = VALUE_BITS_DEF;
	localparam int STIM_BYTES = 1250;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int unsigned src_idle_pct  = 30;
	int unsigned sink_idle_pct = 49;
	int unsigned bytes_sent    = 0;
	logic [7:0]  line_buf [$];

	int unsigned error_count;
	int unsigned pending;
	int unsigned byte_count;
	int unsigned line_count;
	int unsigned target_count;
	int unsigned ceiling_count;

	string key_names [NUM_KEYS] = '{
		"PING", "ABORT", "HOME", "STATUS", "PSTATUS",
		"SSTATUS", "ABS_POS=", "SLEEP", "WAKE"
	};

	acld_line_if                              cmd_ch ();
	acld_result_if #(.VALUE_BITS(VALUE_BITS)) res_ch ();

	ascii_command_line_decoder #(
		.VALUE_BITS(VALUE_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	acld_checker #(
		.VALUE_BITS(VALUE_BITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_ch),
		.res           (res_ch),
		.error_count   (error_count),
		.pending       (pending),
		.byte_count    (byte_count),
		.line_count    (line_count),
		.target_count  (target_count),
		.ceiling_count (ceiling_count)
	);

	always #5 clk = ~clk;

	// The result receiver stalls at random.
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results still outstanding.", pending);
		$display("*** FAILED ***");
		$finish;
	end

	function void append_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_buf.push_back(8'(s[i]));
		end
	endfunction

	function void append_random(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			line_buf.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function void append_digits(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
		end
	endfunction

	function logic [7:0] non_digit();
		int unsigned v;
		v = $urandom_range(0, 245);
		if (v >= 48) begin
			v = v + 10;
		end
		return 8'(v);
	endfunction

	// Position value text: plain digits, values around the ceiling, leading
	// zeros, or digits broken by a non-digit.
	function void append_number();
		longint unsigned near_ceiling [6] = '{
			64'd2147483647, 64'd2147483646, 64'd2147483648,
			64'd214748364, 64'd21474836470, 64'd99999999999
		};
		case ($urandom_range(0, 3))
			0: begin
				append_digits($urandom_range(0, 12));
			end
			1: begin
				append_text($sformatf("%0d", near_ceiling[$urandom_range(0, 5)]));
			end
			2: begin
				append_digits($urandom_range(1, 4) * 0);
				append_text("000");
				append_text($sformatf("%0d", $urandom()));
			end
			default: begin
				append_digits($urandom_range(0, 6));
				line_buf.push_back(non_digit());
				append_digits($urandom_range(0, 6));
			end
		endcase
		if ($urandom_range(0, 3) == 0) begin
			append_random($urandom_range(1, 4));
		end
	endfunction

	// Mostly well-formed command lines, the rest cut, corrupted or noise.
	function void build_random_line();
		int unsigned kind;
		int unsigned k;
		string       text;
		kind = $urandom_range(0, 99);
		k    = $urandom_range(0, NUM_KEYS - 1);
		text = key_names[k];
		if (kind < 60) begin
			append_text(text);
			if (k == KEY_ABS_POS) begin
				append_number();
			end else if ($urandom_range(0, 1) == 0) begin
				append_random($urandom_range(1, 6));
			end
		end else if (kind < 70) begin
			append_text(text.substr(0, $urandom_range(0, text.len() - 2)));
			if ($urandom_range(0, 1) == 0) begin
				append_random(1);
			end
		end else if (kind < 80) begin
			text.putc($urandom_range(0, text.len() - 1), 8'($urandom_range(1, 255)));
			append_text(text);
			if (k == KEY_ABS_POS) begin
				append_number();
			end
		end else if (kind < 90) begin
			// Long lines can run the byte counter into saturation.
			append_text(text);
			if (k == KEY_ABS_POS) begin
				append_digits($urandom_range(8, 14));
			end else begin
				append_random($urandom_range(10, 20));
			end
		end else begin
			append_random($urandom_range(1, 20));
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.line_byte <= b;
		cmd_ch.line_end  <= last;
		do begin
			@(posedge clk);
		end while (cmd_ch.ready !== 1'b1);
		bytes_sent++;
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++) begin
			send_byte(line_buf[i], i == line_buf.size() - 1);
		end
		line_buf.delete();
	endtask

	task automatic send_text(input string s);
		append_text(s);
		send_line();
	endtask

	initial begin
		cmd_ch.valid     = 1'b0;
		cmd_ch.line_byte = '0;
		cmd_ch.line_end  = 1'b0;
		res_ch.ready     = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: each keyword, short and long lines, value limits
		// and the byte extremes.
		foreach (key_names[k]) begin
			send_text(key_names[k]);
		end
		send_text("HOM");
		send_text("HOMEX");
		send_text("ABS_POS=2147483647");
		send_text("ABS_POS=99999999999");
		send_text("ABS_POS=12x34");
		line_buf.push_back(8'h00);
		send_line();
		line_buf.push_back(8'hFF);
		send_line();

		// Random lines over three stall profiles.
		while (bytes_sent < STIM_BYTES) begin
			if (bytes_sent >= 2 * STIM_BYTES / 3) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end else if (bytes_sent >= STIM_BYTES / 3) begin
				src_idle_pct  = 49;
				sink_idle_pct = 30;
			end
			build_random_line();
			send_line();
		end
		cmd_ch.valid <= 1'b0;

		// Drain the outstanding results, then allow for the block's latency.
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("Decoded %0d lines from %0d bytes; %0d were ABS_POS= lines, %0d at the ceiling.",
			line_count, byte_count, target_count, ceiling_count);
		$display("Sender and receiver stalls ran in both proportions, then with no stalls.");
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches found.", error_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
